// ===== src/stm_pkg.sv =====
// ----------------------------------------------------------------------------
// stm_pkg
// Shared constants, types and the 8x8 font for the scrolling text marquee.
// ----------------------------------------------------------------------------
package stm_pkg;

  localparam int SEGMENTS   = 4;
  localparam int TEXT_DEPTH = 64;
  localparam int GLYPH_ROWS = 8;

  localparam int CODE_W       = 7;
  localparam int CHAR_INDEX_W = 6;
  localparam int KIND_W       = 2;
  localparam int PERIOD_W     = 16;
  localparam int BITPOS_W     = 9;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam int ROW_W      = SEGMENTS * 8;
  localparam int ROW_IDX_W  = $clog2(GLYPH_ROWS);
  localparam int CHARS      = SEGMENTS + 1;
  localparam int CHAR_IDX_W = $clog2(CHARS);
  localparam int CNT_W      = $clog2(CHARS + 1);
  localparam int ADDR_W     = $clog2(TEXT_DEPTH);
  localparam int LEN_W      = $clog2(TEXT_DEPTH + 1);
  localparam int SPAN_W     = LEN_W + 3;
  localparam int POS_W      = $clog2(TEXT_DEPTH * 8);

  typedef logic [CODE_W-1:0] char_code_t;
  typedef char_code_t [CHARS-1:0] char_vec_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_FAST  = 2'd2,
    KIND_SLOW  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_LENGTH    = 3'd0,
    CFG_SCROLL_LEFT    = 3'd1,
    CFG_BASE_PERIOD    = 3'd2,
    CFG_PERIOD_STEP    = 3'd3,
    CFG_PERIOD_FLOOR   = 3'd4,
    CFG_PERIOD_CEILING = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row;
    logic [2:0]           shift;
  } row_sel_t;

  function automatic logic [7:0] glyph_row(input char_code_t code,
                                           input logic [ROW_IDX_W-1:0] row);
    logic [63:0] g;
    logic [63:0] sel;
    case (code)
      7'h21: g = 64'h30787830_30003000;
      7'h22: g = 64'h36360000_00000000;
      7'h23: g = 64'h6C6CFE6C_FE6C6C00;
      7'h24: g = 64'h307CC078_0CF83000;
      7'h25: g = 64'h00C6CC18_3066C600;
      7'h26: g = 64'h386C3876_DCCC7600;
      7'h27: g = 64'h06060300_00000000;
      7'h28: g = 64'h180C0606_060C1800;
      7'h29: g = 64'h060C1818_180C0600;
      7'h2A: g = 64'h00663CFF_3C660000;
      7'h2B: g = 64'h000C0C3F_0C0C0000;
      7'h2C: g = 64'h00000000_000C0C06;
      7'h2D: g = 64'h0000003F_00000000;
      7'h2E: g = 64'h00000000_000C0C00;
      7'h2F: g = 64'h6030180C_06030100;
      7'h30: g = 64'h78CCDCFC_ECCC7C00;
      7'h31: g = 64'h30703030_3030FC00;
      7'h32: g = 64'h78CC0C38_60CCFC00;
      7'h33: g = 64'h78CC0C38_0CCC7800;
      7'h34: g = 64'h1C3C6CCC_FE0C1E00;
      7'h35: g = 64'hFCC0F80C_0CCC7800;
      7'h36: g = 64'h3860C0F8_CCCC7800;
      7'h37: g = 64'hFCCC0C18_30303000;
      7'h38: g = 64'h78CCCC78_CCCC7800;
      7'h39: g = 64'h78CCCC7C_0C187000;
      7'h3A: g = 64'h000C0C00_000C0C00;
      7'h3B: g = 64'h000C0C00_000C0C06;
      7'h3C: g = 64'h180C0603_060C1800;
      7'h3D: g = 64'h00003F00_003F0000;
      7'h3E: g = 64'h060C1830_180C0600;
      7'h3F: g = 64'h78CC0C18_30003000;
      7'h40: g = 64'h3E637B7B_7B031E00;
      7'h41: g = 64'h3078CCCC_FCCCCC00;
      7'h42: g = 64'hFC66667C_6666FC00;
      7'h43: g = 64'h3C66C0C0_C0663C00;
      7'h44: g = 64'hF86C6666_666CF800;
      7'h45: g = 64'hFE626878_6862FE00;
      7'h46: g = 64'hFE626878_6860F000;
      7'h47: g = 64'h3C66C0C0_CE663E00;
      7'h48: g = 64'hCCCCCCFC_CCCCCC00;
      7'h49: g = 64'h78303030_30307800;
      7'h4A: g = 64'h1E0C0C0C_CCCC7800;
      7'h4B: g = 64'hF6666C78_6C66F600;
      7'h4C: g = 64'hF0606060_6266FE00;
      7'h4D: g = 64'hC6EEFEFE_D6C6C600;
      7'h4E: g = 64'hC6E6F6DE_CEC6C600;
      7'h4F: g = 64'h386CC6C6_C66C3800;
      7'h50: g = 64'hFC66667C_6060F000;
      7'h51: g = 64'h78CCCCCC_DC781C00;
      7'h52: g = 64'hFC66667C_6C66F600;
      7'h53: g = 64'h78CCE070_1CCC7800;
      7'h54: g = 64'hFCB43030_30307800;
      7'h55: g = 64'hCCCCCCCC_CCCCFC00;
      7'h56: g = 64'hCCCCCCCC_CC783000;
      7'h57: g = 64'hC6C6C6D6_FEEEC600;
      7'h58: g = 64'hC6C66C38_386CC600;
      7'h59: g = 64'hCCCCCC78_30307800;
      7'h5A: g = 64'hFEC68C18_3266FE00;
      7'h5B: g = 64'h1E060606_06061E00;
      7'h5C: g = 64'h03060C18_30604000;
      7'h5D: g = 64'h1E181818_18181E00;
      7'h5E: g = 64'h081C3663_00000000;
      7'h5F: g = 64'h00000000_000000FF;
      7'h60: g = 64'h0C0C1800_00000000;
      7'h61: g = 64'h0000780C_7CCC7600;
      7'h62: g = 64'hE060607C_6666DC00;
      7'h63: g = 64'h000078CC_C0CC7800;
      7'h64: g = 64'h1C0C0C7C_CCCC7600;
      7'h65: g = 64'h000078CC_FCC07800;
      7'h66: g = 64'h386C60F0_6060F000;
      7'h67: g = 64'h000076CC_CC7C0CF8;
      7'h68: g = 64'hE0606C76_6666E600;
      7'h69: g = 64'h30007030_30307800;
      7'h6A: g = 64'h0C000C0C_0CCCCC78;
      7'h6B: g = 64'hE060666C_786CE600;
      7'h6C: g = 64'h70303030_30307800;
      7'h6D: g = 64'h0000CCFE_FED6C600;
      7'h6E: g = 64'h0000F8CC_CCCCCC00;
      7'h6F: g = 64'h000078CC_CCCC7800;
      7'h70: g = 64'h0000DC66_667C60F0;
      7'h71: g = 64'h000076CC_CC7C0C1E;
      7'h72: g = 64'h00009C76_6660F000;
      7'h73: g = 64'h00007CC0_780CF800;
      7'h74: g = 64'h10307C30_30341800;
      7'h75: g = 64'h0000CCCC_CCCC7600;
      7'h76: g = 64'h0000CCCC_CC783000;
      7'h77: g = 64'h0000C6C6_D6FE6C00;
      7'h78: g = 64'h0000C66C_386CC600;
      7'h79: g = 64'h0000CCCC_CC7C0CF8;
      7'h7A: g = 64'h0000FC98_3064FC00;
      7'h7B: g = 64'h380C0C07_0C0C3800;
      7'h7C: g = 64'h18181800_18181800;
      7'h7D: g = 64'h070C0C38_0C0C0700;
      7'h7E: g = 64'h6E3B0000_00000000;
      default: g = 64'h0;
    endcase
    sel = g >> {3'(3'd7 - 3'(row)), 3'b000};
    return sel[7:0];
  endfunction

endpackage

// ===== src/stm_row_pack.sv =====
// ----------------------------------------------------------------------------
// stm_row_pack
// Builds one display row from the fetched character window: each segment
// byte is its glyph row shifted left and filled from the next glyph.
// ----------------------------------------------------------------------------
module stm_row_pack (
  input  stm_pkg::char_vec_t          chars,
  input  stm_pkg::row_sel_t           sel,
  output logic [stm_pkg::ROW_W-1:0]   row_bits
);

  for (genvar s = 0; s < stm_pkg::SEGMENTS; s++) begin : g_seg
    logic [15:0] pair;
    assign pair = {stm_pkg::glyph_row(chars[s], sel.row),
                   stm_pkg::glyph_row(chars[s+1], sel.row)} << sel.shift;
    assign row_bits[stm_pkg::ROW_W-1-8*s -: 8] = pair[15:8];
  end

endmodule

// ===== src/scrolling_text_marquee.sv =====
// ----------------------------------------------------------------------------
// scrolling_text_marquee
// Scrolling text for a chain of 8x8 LED segments: text store, tick timer,
// speed control and row generation from a fixed font.
// ----------------------------------------------------------------------------
// Items go in on start/busy: a transfer happens when start is high and busy
// is low. in_kind selects a 1 ms tick, a character write (in_char_index,
// in_char_code), a speed-up or a slow-down.
// Writes, speed changes and ticks that do not expire leave busy low. An
// expiring tick moves the scroll position one column, then busy stays high
// while the character window is read from the text store, one character a
// cycle, and while eight rows follow on consecutive cycles, one per cycle,
// each marked by out_valid, with out_last on row 7. The next item may follow
// the cycle after the last row.
// The receiver cannot stall: each row is shown for exactly one cycle.
// Configuration registers are to be written on the cfg_ channel (cfg_ready
// is always high) by the user only while the block is idle; the block itself
// has no check for this. Any write to a known register restarts position,
// countdown and period.
// Reset (rst_n low, synchronous) loads the register defaults, position 0
// and countdown/period from the base period. The text store is not cleared.
// ----------------------------------------------------------------------------
module scrolling_text_marquee (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [stm_pkg::KIND_W-1:0]        in_kind,
  input  logic [stm_pkg::CHAR_INDEX_W-1:0]  in_char_index,
  input  logic [stm_pkg::CODE_W-1:0]        in_char_code,
  output logic                              out_valid,
  output logic [stm_pkg::ROW_IDX_W-1:0]     out_row_index,
  output logic [stm_pkg::ROW_W-1:0]         out_row_bits,
  output logic [stm_pkg::BITPOS_W-1:0]      out_bit_position,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_ROWS = 3'b100
  } state_t;

  localparam int PW = stm_pkg::PERIOD_W;

  state_t                          state_r, state_nxt;
  logic [stm_pkg::CODE_W-1:0]      text_length_r, text_length_nxt;
  logic                            scroll_left_r, scroll_left_nxt;
  logic [PW-1:0]                   base_period_r, base_period_nxt;
  logic [PW-1:0]                   period_step_r, period_step_nxt;
  logic [PW-1:0]                   period_floor_r, period_floor_nxt;
  logic [PW-1:0]                   period_ceiling_r, period_ceiling_nxt;
  logic [stm_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [PW-1:0]                   cur_period_r, cur_period_nxt;
  logic [PW-1:0]                   countdown_r, countdown_nxt;
  logic [stm_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [stm_pkg::ADDR_W-1:0]      ptr_r, ptr_nxt;
  logic [stm_pkg::ROW_IDX_W-1:0]   row_r, row_nxt;
  stm_pkg::char_vec_t              chars_r, chars_nxt;

  stm_pkg::char_code_t             text_store [stm_pkg::TEXT_DEPTH];
  stm_pkg::char_code_t             rd_data_r;

  logic                            accept;
  logic                            wr_en;
  logic [stm_pkg::ADDR_W-1:0]      wr_addr;
  logic                            cfg_hit;
  logic [stm_pkg::LEN_W-1:0]       eff_len;
  logic [stm_pkg::SPAN_W-1:0]      span;
  logic [stm_pkg::SPAN_W-1:0]      pos_ext;
  logic [stm_pkg::SPAN_W-1:0]      pos_inc;
  logic [stm_pkg::POS_W-1:0]       step_pos;
  logic [stm_pkg::LEN_W-1:0]       ptr_inc;
  logic [PW-1:0]                   lo_bound;
  logic [PW-1:0]                   hi_bound;
  stm_pkg::row_sel_t               row_sel;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign wr_en     = accept && (stm_pkg::kind_t'(in_kind) == stm_pkg::KIND_WRITE);
  assign wr_addr   = stm_pkg::ADDR_W'(in_char_index % stm_pkg::TEXT_DEPTH);

  // effective length and wrap span
  always_comb begin
    if (text_length_r == '0) begin
      eff_len = stm_pkg::LEN_W'(1);
    end else if (32'(text_length_r) > stm_pkg::TEXT_DEPTH) begin
      eff_len = stm_pkg::LEN_W'(stm_pkg::TEXT_DEPTH);
    end else begin
      eff_len = stm_pkg::LEN_W'(text_length_r);
    end
  end

  assign span    = {eff_len, 3'b000};
  assign pos_ext = stm_pkg::SPAN_W'(pos_r);
  assign pos_inc = pos_ext + 1'b1;

  always_comb begin
    if (scroll_left_r) begin
      step_pos = (pos_inc >= span) ? '0 : stm_pkg::POS_W'(pos_inc);
    end else if (pos_ext == '0 || pos_ext > span) begin
      step_pos = stm_pkg::POS_W'(span - 1'b1);
    end else begin
      step_pos = stm_pkg::POS_W'(pos_ext - 1'b1);
    end
  end

  assign ptr_inc  = stm_pkg::LEN_W'(ptr_r) + 1'b1;
  assign lo_bound = (base_period_r < period_floor_r) ? base_period_r : period_floor_r;
  assign hi_bound = (base_period_r > period_ceiling_r) ? base_period_r : period_ceiling_r;

  always_comb begin
    state_nxt          = state_r;
    text_length_nxt    = text_length_r;
    scroll_left_nxt    = scroll_left_r;
    base_period_nxt    = base_period_r;
    period_step_nxt    = period_step_r;
    period_floor_nxt   = period_floor_r;
    period_ceiling_nxt = period_ceiling_r;
    pos_nxt            = pos_r;
    cur_period_nxt     = cur_period_r;
    countdown_nxt      = countdown_r;
    cnt_nxt            = cnt_r;
    ptr_nxt            = ptr_r;
    row_nxt            = row_r;
    chars_nxt          = chars_r;
    cfg_hit            = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (stm_pkg::kind_t'(in_kind))
            stm_pkg::KIND_TICK: begin
              if (countdown_r > PW'(1)) begin
                countdown_nxt = countdown_r - 1'b1;
              end else begin
                countdown_nxt = cur_period_r;
                pos_nxt       = step_pos;
                ptr_nxt       = stm_pkg::ADDR_W'(step_pos >> 3);
                cnt_nxt       = '0;
                state_nxt     = S_READ;
              end
            end
            stm_pkg::KIND_FAST: begin
              if ({1'b0, cur_period_r} <= {1'b0, lo_bound} + {1'b0, period_step_r}) begin
                cur_period_nxt = lo_bound;
              end else begin
                cur_period_nxt = cur_period_r - period_step_r;
              end
            end
            stm_pkg::KIND_SLOW: begin
              if ({1'b0, cur_period_r} + {1'b0, period_step_r} >= {1'b0, hi_bound}) begin
                cur_period_nxt = hi_bound;
              end else begin
                cur_period_nxt = cur_period_r + period_step_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        cnt_nxt = cnt_r + 1'b1;
        ptr_nxt = (ptr_inc == eff_len) ? '0 : stm_pkg::ADDR_W'(ptr_inc);
        if (cnt_r != '0) begin
          chars_nxt[stm_pkg::CHAR_IDX_W'(cnt_r - 1'b1)] = rd_data_r;
        end
        if (cnt_r == stm_pkg::CNT_W'(stm_pkg::CHARS)) begin
          row_nxt   = '0;
          state_nxt = S_ROWS;
        end
      end
      S_ROWS: begin
        row_nxt = row_r + 1'b1;
        if (row_r == stm_pkg::ROW_IDX_W'(stm_pkg::GLYPH_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      case (stm_pkg::cfg_idx_t'(cfg_index))
        stm_pkg::CFG_TEXT_LENGTH: begin
          text_length_nxt = cfg_data[stm_pkg::CODE_W-1:0];
          cfg_hit         = 1'b1;
        end
        stm_pkg::CFG_SCROLL_LEFT: begin
          scroll_left_nxt = cfg_data[0];
          cfg_hit         = 1'b1;
        end
        stm_pkg::CFG_BASE_PERIOD: begin
          base_period_nxt = cfg_data[PW-1:0];
          cfg_hit         = 1'b1;
        end
        stm_pkg::CFG_PERIOD_STEP: begin
          period_step_nxt = cfg_data[PW-1:0];
          cfg_hit         = 1'b1;
        end
        stm_pkg::CFG_PERIOD_FLOOR: begin
          period_floor_nxt = cfg_data[PW-1:0];
          cfg_hit          = 1'b1;
        end
        stm_pkg::CFG_PERIOD_CEILING: begin
          period_ceiling_nxt = cfg_data[PW-1:0];
          cfg_hit            = 1'b1;
        end
        default: begin
        end
      endcase
      if (cfg_hit) begin
        pos_nxt        = '0;
        cur_period_nxt = base_period_nxt;
        countdown_nxt  = base_period_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      text_length_r    <= stm_pkg::CODE_W'(1);
      scroll_left_r    <= 1'b1;
      base_period_r    <= PW'(100);
      period_step_r    <= PW'(10);
      period_floor_r   <= PW'(20);
      period_ceiling_r <= PW'(1000);
      pos_r            <= '0;
      cur_period_r     <= PW'(100);
      countdown_r      <= PW'(100);
      cnt_r            <= '0;
      row_r            <= '0;
    end else begin
      state_r          <= state_nxt;
      text_length_r    <= text_length_nxt;
      scroll_left_r    <= scroll_left_nxt;
      base_period_r    <= base_period_nxt;
      period_step_r    <= period_step_nxt;
      period_floor_r   <= period_floor_nxt;
      period_ceiling_r <= period_ceiling_nxt;
      pos_r            <= pos_nxt;
      cur_period_r     <= cur_period_nxt;
      countdown_r      <= countdown_nxt;
      cnt_r            <= cnt_nxt;
      row_r            <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    chars_r <= chars_nxt;
  end

  // text store, one write and one read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      text_store[wr_addr] <= in_char_code;
    end
    rd_data_r <= text_store[ptr_r];
  end

  assign row_sel.row   = row_r;
  assign row_sel.shift = pos_r[2:0];

  stm_row_pack u_row_pack (
    .chars    (chars_r),
    .sel      (row_sel),
    .row_bits (out_row_bits)
  );

  assign out_valid        = (state_r == S_ROWS);
  assign out_row_index    = row_r;
  assign out_bit_position = stm_pkg::BITPOS_W'(pos_r);
  assign out_last         = out_valid &&
                            (row_r == stm_pkg::ROW_IDX_W'(stm_pkg::GLYPH_ROWS - 1));

`ifndef SYNTHESIS
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !busy)
    else $error("frame did not end after last row");

  a_rows_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && (out_row_index == $past(out_row_index) + 1'b1))
    else $error("rows not consecutive");

  a_pos_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (pos_ext < span))
    else $error("scroll position outside span");

  a_expiry_steps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (stm_pkg::kind_t'(in_kind) == stm_pkg::KIND_TICK) && (countdown_r <= PW'(1))
    |=> busy)
    else $error("expired tick did not start a frame");
`endif

endmodule

// ===== verif/scrolling_text_marquee_tb.sv =====
// ----------------------------------------------------------------------------
// scrolling_text_marquee_tb
// Drives ticks, character writes and speed changes into the marquee, keeps
// its own model of the text store, timer and scroll position, and checks
// every emitted display row against the predicted frame. Register settings
// change between phases, from the defaults out to the extremes.
// ----------------------------------------------------------------------------
module scrolling_text_marquee_tb;

  localparam logic [stm_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
  localparam int ITEM_TARGET  = 310;
  localparam int FRAME_TARGET = 40;
  localparam int PHASE_ITEMS  = 24;
  localparam int SETTLE       = stm_pkg::SEGMENTS + 12;
  localparam int CYCLE_LIMIT  = 300000;

  // glyphs for codes 0x20 to 0x7f, first entry in the top bits, row 0 in the top byte
  localparam logic [96*64-1:0] FONT_ROWS = {
    64'h0,                 64'h30787830_30003000, 64'h36360000_00000000, 64'h6C6CFE6C_FE6C6C00,
    64'h307CC078_0CF83000, 64'h00C6CC18_3066C600, 64'h386C3876_DCCC7600, 64'h06060300_00000000,
    64'h180C0606_060C1800, 64'h060C1818_180C0600, 64'h00663CFF_3C660000, 64'h000C0C3F_0C0C0000,
    64'h00000000_000C0C06, 64'h0000003F_00000000, 64'h00000000_000C0C00, 64'h6030180C_06030100,
    64'h78CCDCFC_ECCC7C00, 64'h30703030_3030FC00, 64'h78CC0C38_60CCFC00, 64'h78CC0C38_0CCC7800,
    64'h1C3C6CCC_FE0C1E00, 64'hFCC0F80C_0CCC7800, 64'h3860C0F8_CCCC7800, 64'hFCCC0C18_30303000,
    64'h78CCCC78_CCCC7800, 64'h78CCCC7C_0C187000, 64'h000C0C00_000C0C00, 64'h000C0C00_000C0C06,
    64'h180C0603_060C1800, 64'h00003F00_003F0000, 64'h060C1830_180C0600, 64'h78CC0C18_30003000,
    64'h3E637B7B_7B031E00, 64'h3078CCCC_FCCCCC00, 64'hFC66667C_6666FC00, 64'h3C66C0C0_C0663C00,
    64'hF86C6666_666CF800, 64'hFE626878_6862FE00, 64'hFE626878_6860F000, 64'h3C66C0C0_CE663E00,
    64'hCCCCCCFC_CCCCCC00, 64'h78303030_30307800, 64'h1E0C0C0C_CCCC7800, 64'hF6666C78_6C66F600,
    64'hF0606060_6266FE00, 64'hC6EEFEFE_D6C6C600, 64'hC6E6F6DE_CEC6C600, 64'h386CC6C6_C66C3800,
    64'hFC66667C_6060F000, 64'h78CCCCCC_DC781C00, 64'hFC66667C_6C66F600, 64'h78CCE070_1CCC7800,
    64'hFCB43030_30307800, 64'hCCCCCCCC_CCCCFC00, 64'hCCCCCCCC_CC783000, 64'hC6C6C6D6_FEEEC600,
    64'hC6C66C38_386CC600, 64'hCCCCCC78_30307800, 64'hFEC68C18_3266FE00, 64'h1E060606_06061E00,
    64'h03060C18_30604000, 64'h1E181818_18181E00, 64'h081C3663_00000000, 64'h00000000_000000FF,
    64'h0C0C1800_00000000, 64'h0000780C_7CCC7600, 64'hE060607C_6666DC00, 64'h000078CC_C0CC7800,
    64'h1C0C0C7C_CCCC7600, 64'h000078CC_FCC07800, 64'h386C60F0_6060F000, 64'h000076CC_CC7C0CF8,
    64'hE0606C76_6666E600, 64'h30007030_30307800, 64'h0C000C0C_0CCCCC78, 64'hE060666C_786CE600,
    64'h70303030_30307800, 64'h0000CCFE_FED6C600, 64'h0000F8CC_CCCCCC00, 64'h000078CC_CCCC7800,
    64'h0000DC66_667C60F0, 64'h000076CC_CC7C0C1E, 64'h00009C76_6660F000, 64'h00007CC0_780CF800,
    64'h10307C30_30341800, 64'h0000CCCC_CCCC7600, 64'h0000CCCC_CC783000, 64'h0000C6C6_D6FE6C00,
    64'h0000C66C_386CC600, 64'h0000CCCC_CC7C0CF8, 64'h0000FC98_3064FC00, 64'h380C0C07_0C0C3800,
    64'h18181800_18181800, 64'h070C0C38_0C0C0700, 64'h6E3B0000_00000000, 64'h0
  };

  typedef struct packed {
    logic [stm_pkg::ROW_IDX_W-1:0] row_index;
    logic [stm_pkg::ROW_W-1:0]     row_bits;
    logic [stm_pkg::BITPOS_W-1:0]  bit_position;
    logic                          is_last;
  } marquee_row_t;

  class marquee_scoreboard;
    logic [6:0]   length_reg;
    logic         scroll_left_reg;
    int           base_reg, step_reg, floor_reg, ceiling_reg;
    logic [6:0]   text [stm_pkg::TEXT_DEPTH];
    int           position, period, countdown;
    int           frames, errors;
    marquee_row_t expected_rows[$];

    function new();
      length_reg      = 7'd1;
      scroll_left_reg = 1'b1;
      base_reg        = 100;
      step_reg        = 10;
      floor_reg       = 20;
      ceiling_reg     = 1000;
      foreach (text[i]) text[i] = '0;
      frames = 0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      position  = 0;
      period    = base_reg;
      countdown = base_reg;
    endfunction

    function int font_row(int code, int row);
      logic [63:0] g;
      if (code < 32) return 0;
      g = FONT_ROWS[(127 - code) * 64 +: 64];
      g = g >> (8 * (7 - row));
      return int'(g[7:0]);
    endfunction

    function void load_register(logic [stm_pkg::CFG_IDX_W-1:0] idx,
                                logic [stm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        stm_pkg::CFG_TEXT_LENGTH:    length_reg = data[6:0];
        stm_pkg::CFG_SCROLL_LEFT:    scroll_left_reg = data[0];
        stm_pkg::CFG_BASE_PERIOD:    base_reg = int'(data);
        stm_pkg::CFG_PERIOD_STEP:    step_reg = int'(data);
        stm_pkg::CFG_PERIOD_FLOOR:   floor_reg = int'(data);
        stm_pkg::CFG_PERIOD_CEILING: ceiling_reg = int'(data);
        default: return;
      endcase
      restart();
    endfunction

    function void note_item(stm_pkg::kind_t kind, logic [stm_pkg::CHAR_INDEX_W-1:0] slot,
                            logic [stm_pkg::CODE_W-1:0] code);
      int lo, hi, len, span, sh, ci, a, b, pix;
      logic [stm_pkg::ROW_W-1:0] bits;
      marquee_row_t row;
      case (kind)
        stm_pkg::KIND_WRITE: begin
          text[slot] = code;
          return;
        end
        stm_pkg::KIND_FAST: begin
          lo = (base_reg < floor_reg) ? base_reg : floor_reg;
          if (period <= lo + step_reg) period = lo;
          else period -= step_reg;
          return;
        end
        stm_pkg::KIND_SLOW: begin
          hi = (base_reg > ceiling_reg) ? base_reg : ceiling_reg;
          if (period + step_reg >= hi) period = hi;
          else period += step_reg;
          return;
        end
        default: ;
      endcase
      if (countdown > 1) begin
        countdown--;
        return;
      end
      countdown = period;
      len  = (length_reg == 0) ? 1 : (length_reg > stm_pkg::TEXT_DEPTH) ? stm_pkg::TEXT_DEPTH
           : int'(length_reg);
      span = len * 8;
      if (scroll_left_reg) begin
        position++;
        if (position >= span) position = 0;
      end else if (position == 0 || position > span) begin
        position = span - 1;
      end else begin
        position--;
      end
      sh = position % 8;
      ci = position / 8;
      for (int r = 0; r < stm_pkg::GLYPH_ROWS; r++) begin
        bits = '0;
        for (int s = 0; s < stm_pkg::SEGMENTS; s++) begin
          a    = int'(text[(ci + s) % len]);
          b    = int'(text[(ci + s + 1) % len]);
          pix  = ((font_row(a, r) << sh) | (font_row(b, r) >> (8 - sh))) & 255;
          bits = (bits << 8) | stm_pkg::ROW_W'(pix);
        end
        row.row_index    = stm_pkg::ROW_IDX_W'(r);
        row.row_bits     = bits;
        row.bit_position = stm_pkg::BITPOS_W'(position);
        row.is_last      = (r == stm_pkg::GLYPH_ROWS - 1);
        expected_rows.push_back(row);
      end
      frames++;
    endfunction

    function void check_row(marquee_row_t got);
      marquee_row_t want;
      if (expected_rows.size() == 0) begin
        $error("row %0d arrived with no frame expected", got.row_index);
        errors++;
        return;
      end
      want = expected_rows.pop_front();
      if (got.row_index !== want.row_index) begin
        $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
        errors++;
      end
      if (got.row_bits !== want.row_bits) begin
        $error("row_bits: expected %h, got %h", want.row_bits, got.row_bits);
        errors++;
      end
      if (got.bit_position !== want.bit_position) begin
        $error("bit_position: expected %0d, got %0d", want.bit_position, got.bit_position);
        errors++;
      end
      if (got.is_last !== want.is_last) begin
        $error("last: expected %0d, got %0d", want.is_last, got.is_last);
        errors++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic [stm_pkg::KIND_W-1:0]       in_kind;
  logic [stm_pkg::CHAR_INDEX_W-1:0] in_char_index;
  logic [stm_pkg::CODE_W-1:0]       in_char_code;
  logic                             out_valid;
  logic [stm_pkg::ROW_IDX_W-1:0]    out_row_index;
  logic [stm_pkg::ROW_W-1:0]        out_row_bits;
  logic [stm_pkg::BITPOS_W-1:0]     out_bit_position;
  logic                             out_last;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [stm_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [stm_pkg::CFG_DATA_W-1:0]   cfg_data;

  marquee_scoreboard sb;
  bit                written [stm_pkg::TEXT_DEPTH];
  int                items_sent;
  int                cycle_count;

  scrolling_text_marquee dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_char_index    (in_char_index),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_row_index    (out_row_index),
    .out_row_bits     (out_row_bits),
    .out_bit_position (out_bit_position),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // register writes, item transfers and rows as seen at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.load_register(cfg_index, cfg_data);
      if (start && !busy)
        sb.note_item(stm_pkg::kind_t'(in_kind), in_char_index, in_char_code);
      if (out_valid)
        sb.check_row(marquee_row_t'({out_row_index, out_row_bits, out_bit_position, out_last}));
    end
  end

  task automatic send_item(stm_pkg::kind_t kind, int slot, int code);
    @(negedge clk);
    start         <= 1'b1;
    in_kind       <= kind;
    in_char_index <= slot[stm_pkg::CHAR_INDEX_W-1:0];
    in_char_code  <= code[stm_pkg::CODE_W-1:0];
    while (busy) @(negedge clk);
    @(posedge clk);
    if (kind == stm_pkg::KIND_WRITE) written[slot[stm_pkg::CHAR_INDEX_W-1:0]] = 1'b1;
    items_sent++;
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start         <= 1'b0;
    in_kind       <= stm_pkg::kind_t'($urandom_range(3));
    in_char_index <= stm_pkg::CHAR_INDEX_W'($urandom);
    in_char_code  <= stm_pkg::CODE_W'($urandom);
    @(posedge clk);
  endtask

  task automatic pause_sender(int pct);
    while ($urandom_range(99) < pct) idle_cycle();
  endtask

  task automatic wait_idle();
    idle_cycle();
    while (sb.expected_rows.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(logic [stm_pkg::CFG_IDX_W-1:0] idx,
                                logic [stm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // every slot inside the loop must hold a character before a step reads it
  task automatic fill_text();
    int len;
    len = (sb.length_reg == 0) ? 1
        : (sb.length_reg > stm_pkg::TEXT_DEPTH) ? stm_pkg::TEXT_DEPTH
        : int'(sb.length_reg);
    for (int i = 0; i < len; i++)
      if (!written[i]) send_item(stm_pkg::KIND_WRITE, i, $urandom_range(126, 33));
  endtask

  task automatic configure_phase();
    logic [stm_pkg::CFG_DATA_W-1:0] d;
    bit relaxed;
    relaxed = (items_sent < ITEM_TARGET);
    d = stm_pkg::CFG_DATA_W'($urandom);
    case ($urandom_range(9))
      0: d[6:0] = 7'd0;
      1: d[6:0] = 7'd64;
      2: d[6:0] = 7'($urandom_range(127, 65));
      3: d[6:0] = 7'd1;
      default: d[6:0] = 7'($urandom_range(12, 2));
    endcase
    write_register(stm_pkg::CFG_TEXT_LENGTH, d);
    write_register(stm_pkg::CFG_SCROLL_LEFT, stm_pkg::CFG_DATA_W'($urandom));
    d = stm_pkg::CFG_DATA_W'($urandom_range(4));
    if (relaxed && $urandom_range(7) == 0) d = 16'hFFFF;
    else if (relaxed && $urandom_range(7) == 0) d = stm_pkg::CFG_DATA_W'($urandom);
    write_register(stm_pkg::CFG_BASE_PERIOD, d);
    d = stm_pkg::CFG_DATA_W'($urandom_range(3, 1));
    if ($urandom_range(5) == 0) d = '0;
    else if (relaxed && $urandom_range(6) == 0) d = 16'hFFFF;
    write_register(stm_pkg::CFG_PERIOD_STEP, d);
    d = stm_pkg::CFG_DATA_W'($urandom_range(6));
    if ($urandom_range(7) == 0) d = 16'hFFFF;
    else if ($urandom_range(7) == 0) d = stm_pkg::CFG_DATA_W'($urandom);
    write_register(stm_pkg::CFG_PERIOD_FLOOR, d);
    d = stm_pkg::CFG_DATA_W'($urandom_range(12, 1));
    if (relaxed && $urandom_range(7) == 0) d = 16'hFFFF;
    else if (relaxed && $urandom_range(7) == 0) d = stm_pkg::CFG_DATA_W'($urandom);
    write_register(stm_pkg::CFG_PERIOD_CEILING, d);
    if ($urandom_range(3) == 0) write_register(CFG_NO_REG, stm_pkg::CFG_DATA_W'($urandom));
  endtask

  task automatic random_item();
    int pick, code;
    pick = $urandom_range(99);
    code = $urandom_range(1) ? $urandom_range(126, 33) : $urandom_range(127);
    if (pick < 60)
      send_item(stm_pkg::KIND_TICK, $urandom_range(63), $urandom_range(127));
    else if (pick < 80)
      send_item(stm_pkg::KIND_WRITE, $urandom_range(63), code);
    else if (pick < 90)
      send_item(stm_pkg::KIND_FAST, $urandom_range(63), $urandom_range(127));
    else
      send_item(stm_pkg::KIND_SLOW, $urandom_range(63), $urandom_range(127));
  endtask

  initial begin
    int ph;
    int idle_pct;
    sb            = new();
    items_sent    = 0;
    cycle_count   = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_kind       = stm_pkg::KIND_TICK;
    in_char_index = '0;
    in_char_code  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = stm_pkg::CFG_TEXT_LENGTH;
    cfg_data      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults: extreme slot and code, speed changes, a tick short of expiry
    send_item(stm_pkg::KIND_WRITE, 63, 127);
    send_item(stm_pkg::KIND_WRITE, 0, 8'h48);
    send_item(stm_pkg::KIND_FAST, 0, 0);
    send_item(stm_pkg::KIND_FAST, 63, 127);
    send_item(stm_pkg::KIND_SLOW, 0, 0);
    send_item(stm_pkg::KIND_TICK, 0, 0);
    wait_idle();

    // zero length and zero period, scrolling right, clamps at both bounds
    write_register(stm_pkg::CFG_TEXT_LENGTH, 16'd0);
    write_register(stm_pkg::CFG_SCROLL_LEFT, 16'd0);
    write_register(stm_pkg::CFG_BASE_PERIOD, 16'd0);
    write_register(stm_pkg::CFG_PERIOD_STEP, 16'hFFFF);
    write_register(stm_pkg::CFG_PERIOD_FLOOR, 16'd0);
    write_register(stm_pkg::CFG_PERIOD_CEILING, 16'hFFFF);
    send_item(stm_pkg::KIND_TICK, 0, 0);
    send_item(stm_pkg::KIND_TICK, 0, 0);
    send_item(stm_pkg::KIND_FAST, 0, 0);
    send_item(stm_pkg::KIND_SLOW, 0, 0);
    send_item(stm_pkg::KIND_TICK, 0, 0);
    send_item(stm_pkg::KIND_WRITE, 0, 0);
    send_item(stm_pkg::KIND_TICK, 0, 0);
    wait_idle();

    // period of one, scrolling left through the wrap
    write_register(stm_pkg::CFG_SCROLL_LEFT, 16'd1);
    write_register(stm_pkg::CFG_BASE_PERIOD, 16'd1);
    write_register(CFG_NO_REG, 16'hFFFF);
    send_item(stm_pkg::KIND_WRITE, 0, 8'h5A);
    repeat (9) send_item(stm_pkg::KIND_TICK, 0, 0);

    ph = 0;
    while (items_sent < ITEM_TARGET || sb.frames < FRAME_TARGET) begin
      wait_idle();
      configure_phase();
      fill_text();
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 77 : 9;
      repeat (PHASE_ITEMS) begin
        random_item();
        pause_sender(idle_pct);
      end
      ph++;
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_rows.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
